/* hdl/slht_pkg.sv */
// shared constants, types and tables for the segment length, heading and turn block
package slht_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF   = 8;
    localparam int ITERS           = 20;
    localparam int ITER_W          = $clog2(ITERS);
    localparam int ZFRAC           = 24;
    localparam int GUARD           = 4;
    localparam int GAIN_W          = 30;
    localparam int Z_WIDTH         = ZFRAC + 12;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [GAIN_W-1:0] INV_GAIN = GAIN_W'(652032874);

    localparam logic signed [Z_WIDTH-1:0] Z_HALF = Z_WIDTH'(64'd180 << ZFRAC);
    localparam logic signed [Z_WIDTH-1:0] Z_FULL = Z_WIDTH'(64'd360 << ZFRAC);

    // atan(2^-i) in degrees
    localparam logic signed [Z_WIDTH-1:0] ATAN_TAB [ITERS] = '{
        Z_WIDTH'(754974720), Z_WIDTH'(445687602), Z_WIDTH'(235489088),
        Z_WIDTH'(119537938), Z_WIDTH'(60000934),  Z_WIDTH'(30029717),
        Z_WIDTH'(15018523),  Z_WIDTH'(7509720),   Z_WIDTH'(3754917),
        Z_WIDTH'(1877466),   Z_WIDTH'(938734),    Z_WIDTH'(469367),
        Z_WIDTH'(234684),    Z_WIDTH'(117342),    Z_WIDTH'(58671),
        Z_WIDTH'(29335),     Z_WIDTH'(14668),     Z_WIDTH'(7334),
        Z_WIDTH'(3667),      Z_WIDTH'(1833)
    };

    typedef struct packed {
        logic is_zero;
        logic is_neg;
    } t_seg_flags;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_INIT,
        S_ITER,
        S_WRAP,
        S_ROUND,
        S_TURN
    } t_state;

endpackage

/* hdl/slht_seg_if.sv */
// segment input channel: valid, ready and the start and end points
interface slht_seg_if #(
    parameter int COORD_WIDTH = slht_pkg::COORD_WIDTH_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;

    modport source (output valid, output start_x, output start_y,
                    output end_x, output end_y, input ready);
    modport sink   (input valid, input start_x, input start_y,
                    input end_x, input end_y, output ready);
endinterface

/* hdl/slht_res_if.sv */
// result channel: valid, ready, length and turn
interface slht_res_if #(
    parameter int COORD_WIDTH = slht_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = slht_pkg::FRAC_BITS_DEF
) ();
    localparam int LEN_WIDTH = COORD_WIDTH + 1 + FRAC_BITS;
    localparam int ANG_WIDTH = FRAC_BITS + 9;

    logic                        valid;
    logic                        ready;
    logic [LEN_WIDTH-1:0]        seg_length;
    logic signed [ANG_WIDTH-1:0] turn_angle;
    logic                        turn_valid;

    modport source (output valid, output seg_length, output turn_angle,
                    output turn_valid, input ready);
    modport sink   (input valid, input seg_length, input turn_angle,
                    input turn_valid, output ready);
endinterface

/* hdl/segment_length_heading_turn.sv */
// top level: segment length, heading and turn by iterative cordic vectoring
// zero-length segments skip the gain multiply and cordic steps and go to wrap and rounding
// one segment at a time through the 20 steps of the single shared cordic add/shift unit plus
// gain multiply, rounding and turn steps; a 2-entry queue ahead of it takes further segments
// reset: synchronous active low, clears queue, stored heading and history, no result pending
module segment_length_heading_turn #(
    parameter int COORD_WIDTH = slht_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = slht_pkg::FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    slht_seg_if.sink   i_seg,
    slht_res_if.source o_res
);
    localparam int QW = 2 * (COORD_WIDTH + 1) + $bits(slht_pkg::t_seg_flags);

    logic          push_valid;
    logic          push_ready;
    logic [QW-1:0] push_data;
    logic          pop_valid;
    logic          pop_ready;
    logic [QW-1:0] pop_data;

    slht_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .QW          (QW)
    ) u_front (
        .i_seg        (i_seg),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    slht_fifo #(
        .WIDTH (QW)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    slht_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS),
        .QW          (QW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_data  (pop_data),
        .o_res       (o_res)
    );

endmodule

/* hdl/slht_front.sv */
// front end: takes segments, forms the difference vector and classifies it
module slht_front #(
    parameter int COORD_WIDTH = slht_pkg::COORD_WIDTH_DEF,
    parameter int QW          = 2 * (COORD_WIDTH + 1) + $bits(slht_pkg::t_seg_flags)
) (
    slht_seg_if.sink     i_seg,
    output logic         o_push_valid,
    input  logic         i_push_ready,
    output logic [QW-1:0] o_push_data
);
    localparam int DW = COORD_WIDTH + 1;

    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    slht_pkg::t_seg_flags flags;

    always_comb begin
        dx = {i_seg.end_x[COORD_WIDTH-1], i_seg.end_x}
           - {i_seg.start_x[COORD_WIDTH-1], i_seg.start_x};
        dy = {i_seg.end_y[COORD_WIDTH-1], i_seg.end_y}
           - {i_seg.start_y[COORD_WIDTH-1], i_seg.start_y};
        flags.is_zero = (dx == '0) && (dy == '0);
        flags.is_neg  = dx[DW-1];
    end

    assign o_push_valid = i_seg.valid;
    assign i_seg.ready  = i_push_ready;
    assign o_push_data  = {flags, dx, dy};

endmodule

/* hdl/slht_fifo.sv */
// short queue between the front end and the cordic back end
module slht_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);
    localparam int DEPTH = slht_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        n_count = r_count + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

/* hdl/slht_back.sv */
// back end: gain scaling, iterative cordic vectoring, rounding and turn tracking
module slht_back #(
    parameter int COORD_WIDTH = slht_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = slht_pkg::FRAC_BITS_DEF,
    parameter int QW          = 2 * (COORD_WIDTH + 1) + $bits(slht_pkg::t_seg_flags)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_pop_valid,
    output logic          o_pop_ready,
    input  logic [QW-1:0] i_pop_data,
    slht_res_if.source    o_res
);
    localparam int DW   = COORD_WIDTH + 1;
    localparam int PW   = DW + slht_pkg::GAIN_W + 1;
    localparam int SH   = 30 - FRAC_BITS - slht_pkg::GUARD;
    localparam int XW   = COORD_WIDTH + FRAC_BITS + slht_pkg::GUARD + 3;
    localparam int ZW   = slht_pkg::Z_WIDTH;
    localparam int LW   = COORD_WIDTH + 1 + FRAC_BITS;
    localparam int AW   = FRAC_BITS + 9;
    localparam int TW   = AW + 2;
    localparam int RSH  = slht_pkg::ZFRAC - FRAC_BITS;
    localparam int IW   = slht_pkg::ITER_W;

    localparam logic [AW-1:0] A_FULL = AW'(360) << FRAC_BITS;
    localparam logic signed [TW-1:0] T_HALF = TW'(180) << FRAC_BITS;
    localparam logic signed [TW-1:0] T_FULL = TW'(360) << FRAC_BITS;
    localparam logic [ZW-1:0] Z_RND = ZW'(1) << (RSH - 1);
    localparam logic [XW-1:0] X_RND = XW'(1) << (slht_pkg::GUARD - 1);
    localparam logic [XW-slht_pkg::GUARD-1:0] L_MAX = {LW{1'b1}};

    slht_pkg::t_seg_flags   pop_flags;
    logic signed [DW-1:0]   pop_dx;
    logic signed [DW-1:0]   pop_dy;

    slht_pkg::t_state       r_state, n_state;
    logic [IW-1:0]          r_iter, n_iter;
    logic                   r_out_valid, n_out_valid;
    logic                   r_have, n_have;
    logic [AW-1:0]          r_prev, n_prev;

    logic signed [DW-1:0]   r_dx, n_dx;
    logic signed [DW-1:0]   r_dy, n_dy;
    logic                   r_neg, n_neg;
    logic signed [PW-1:0]   r_px, n_px;
    logic signed [PW-1:0]   r_py, n_py;
    logic signed [XW-1:0]   r_x, n_x;
    logic signed [XW-1:0]   r_y, n_y;
    logic signed [ZW-1:0]   r_z, n_z;
    logic [AW-1:0]          r_head, n_head;
    logic [LW-1:0]          r_len, n_len;
    logic [LW-1:0]          r_out_len, n_out_len;
    logic signed [AW-1:0]   r_out_turn, n_out_turn;
    logic                   r_out_tv, n_out_tv;

    logic signed [XW-1:0]   xs;
    logic signed [XW-1:0]   ys;
    logic signed [XW-1:0]   sx;
    logic signed [XW-1:0]   sy;
    logic [ZW-1:0]          zr;
    logic [AW-1:0]          hq;
    logic [XW-1:0]          lsum;
    logic [XW-slht_pkg::GUARD-1:0] lq;
    logic signed [TW-1:0]   td;
    logic                   load;

    assign {pop_flags, pop_dx, pop_dy} = i_pop_data;
    assign load = (r_state == slht_pkg::S_TURN) && (!r_out_valid || o_res.ready);

    always_comb begin
        n_state     = r_state;
        n_iter      = r_iter;
        n_have      = r_have;
        n_prev      = r_prev;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_neg       = r_neg;
        n_px        = r_px;
        n_py        = r_py;
        n_x         = r_x;
        n_y         = r_y;
        n_z         = r_z;
        n_head      = r_head;
        n_len       = r_len;
        n_out_len   = r_out_len;
        n_out_turn  = r_out_turn;
        n_out_tv    = r_out_tv;
        n_out_valid = r_out_valid && !o_res.ready;
        o_pop_ready = 1'b0;

        xs   = r_x >>> r_iter;
        ys   = r_y >>> r_iter;
        sx   = XW'(r_px >>> SH);
        sy   = XW'(r_py >>> SH);
        zr   = ZW'(r_z) + Z_RND;
        hq   = AW'(zr >> RSH);
        lsum = XW'(r_x) + X_RND;
        lq   = (XW - slht_pkg::GUARD)'(lsum >> slht_pkg::GUARD);
        td   = $signed({2'b00, r_prev}) - $signed({2'b00, r_head});

        unique case (r_state)
            slht_pkg::S_IDLE: begin
                o_pop_ready = 1'b1;
                if (i_pop_valid) begin
                    n_dx  = pop_dx;
                    n_dy  = pop_dy;
                    n_neg = pop_flags.is_neg;
                    if (pop_flags.is_zero) begin
                        n_x     = '0;
                        n_z     = '0;
                        n_state = slht_pkg::S_WRAP;
                    end else begin
                        n_state = slht_pkg::S_MUL;
                    end
                end
            end
            slht_pkg::S_MUL: begin
                n_px    = r_dx * $signed({1'b0, slht_pkg::INV_GAIN});
                n_py    = r_dy * $signed({1'b0, slht_pkg::INV_GAIN});
                n_state = slht_pkg::S_INIT;
            end
            slht_pkg::S_INIT: begin
                n_x     = r_neg ? -sx : sx;
                n_y     = r_neg ? -sy : sy;
                n_z     = r_neg ? slht_pkg::Z_HALF : '0;
                n_iter  = '0;
                n_state = slht_pkg::S_ITER;
            end
            slht_pkg::S_ITER: begin
                if (!r_y[XW-1]) begin
                    n_x = r_x + ys;
                    n_y = r_y - xs;
                    n_z = r_z + slht_pkg::ATAN_TAB[r_iter];
                end else begin
                    n_x = r_x - ys;
                    n_y = r_y + xs;
                    n_z = r_z - slht_pkg::ATAN_TAB[r_iter];
                end
                if (r_iter == IW'(slht_pkg::ITERS - 1)) begin
                    n_state = slht_pkg::S_WRAP;
                end else begin
                    n_iter = r_iter + 1'b1;
                end
            end
            slht_pkg::S_WRAP: begin
                if (r_z[ZW-1]) begin
                    n_z = r_z + slht_pkg::Z_FULL;
                end
                n_state = slht_pkg::S_ROUND;
            end
            slht_pkg::S_ROUND: begin
                n_head = (hq >= A_FULL) ? hq - A_FULL : hq;
                priority if (r_x[XW-1] || r_x == '0) begin
                    n_len = '0;
                end else if (lq > L_MAX) begin
                    n_len = {LW{1'b1}};
                end else begin
                    n_len = LW'(lq);
                end
                n_state = slht_pkg::S_TURN;
            end
            slht_pkg::S_TURN: begin
                if (load) begin
                    n_out_valid = 1'b1;
                    n_out_len   = r_len;
                    n_out_tv    = r_have;
                    priority if (!r_have) begin
                        n_out_turn = '0;
                    end else if (td > T_HALF) begin
                        n_out_turn = AW'(td - T_FULL);
                    end else if (td < -T_HALF) begin
                        n_out_turn = AW'(td + T_FULL);
                    end else begin
                        n_out_turn = AW'(td);
                    end
                    n_prev  = r_head;
                    n_have  = 1'b1;
                    n_state = slht_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = slht_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= slht_pkg::S_IDLE;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
            r_have      <= 1'b0;
            r_prev      <= '0;
        end else begin
            r_state     <= n_state;
            r_iter      <= n_iter;
            r_out_valid <= n_out_valid;
            r_have      <= n_have;
            r_prev      <= n_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx       <= n_dx;
        r_dy       <= n_dy;
        r_neg      <= n_neg;
        r_px       <= n_px;
        r_py       <= n_py;
        r_x        <= n_x;
        r_y        <= n_y;
        r_z        <= n_z;
        r_head     <= n_head;
        r_len      <= n_len;
        r_out_len  <= n_out_len;
        r_out_turn <= n_out_turn;
        r_out_tv   <= n_out_tv;
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.seg_length = r_out_len;
    assign o_res.turn_angle = r_out_turn;
    assign o_res.turn_valid = r_out_tv;

    a_iter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == slht_pkg::S_ITER |-> r_iter < IW'(slht_pkg::ITERS))
        else $error("cordic iteration count out of range");

    a_prev_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prev < A_FULL)
        else $error("stored heading not below a full circle");

    a_have_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have |=> r_have)
        else $error("heading history lost");

    a_no_turn_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.turn_valid |-> o_res.turn_angle == '0)
        else $error("turn reported without a previous heading");

    a_turn_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.turn_valid |->
        ($signed(o_res.turn_angle) <= $signed(AW'(T_HALF)) &&
         $signed(o_res.turn_angle) >= -$signed(AW'(T_HALF))))
        else $error("turn outside half circle");

endmodule

/* dv/tb_top.sv */
// testbench for segment_length_heading_turn: table of directed segments, then random paths
`timescale 1ns / 1ps

module tb_top;

    localparam int COORD_W = slht_pkg::COORD_WIDTH_DEF;
    localparam int FRAC_W  = slht_pkg::FRAC_BITS_DEF;
    localparam int LEN_W   = COORD_W + 1 + FRAC_W;
    localparam int ANG_W   = FRAC_W + 9;

    localparam int     N_STEPS     = 20;
    localparam int     Z_FRAC      = 24;
    localparam int     LEN_GUARD   = 4;
    localparam longint GAIN_Q30    = 64'sd652032874;
    localparam int     GAIN_SHIFT  = 30 - FRAC_W - LEN_GUARD;
    localparam longint Z_HALF_TURN = 64'sd180 <<< Z_FRAC;
    localparam longint Z_FULL_TURN = 64'sd360 <<< Z_FRAC;
    localparam longint HALF_TURN   = 64'sd180 <<< FRAC_W;
    localparam longint FULL_TURN   = 64'sd360 <<< FRAC_W;
    localparam longint LEN_MAX     = (64'sd1 <<< LEN_W) - 64'sd1;

    localparam longint ATAN_DEG [N_STEPS] = '{
        64'sd754974720, 64'sd445687602, 64'sd235489088, 64'sd119537938, 64'sd60000934,
        64'sd30029717,  64'sd15018523,  64'sd7509720,   64'sd3754917,   64'sd1877466,
        64'sd938734,    64'sd469367,    64'sd234684,    64'sd117342,    64'sd58671,
        64'sd29335,     64'sd14668,     64'sd7334,      64'sd3667,      64'sd1833
    };

    localparam int RANDOM_ITEMS = 2000;
    localparam int DRAIN_CYCLES = 60;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] ey;
    } t_segment;

    typedef struct packed {
        logic [LEN_W-1:0]        length;
        logic signed [ANG_W-1:0] turn;
        logic                    turn_valid;
    } t_turn_result;

    typedef struct packed {
        t_segment     seg;
        logic         typed;
        t_turn_result want;
    } t_vector;

    localparam logic signed [COORD_W-1:0] C0   = 16'sd0;
    localparam logic signed [COORD_W-1:0] CP1  = 16'sd1;
    localparam logic signed [COORD_W-1:0] CM1  = -16'sd1;
    localparam logic signed [COORD_W-1:0] CMAX = 16'sh7fff;
    localparam logic signed [COORD_W-1:0] CMIN = 16'sh8000;

    localparam t_turn_result NO_TURN_ZERO = '{25'd0, 17'sd0, 1'b0};
    localparam t_turn_result TURN_ZERO    = '{25'd0, 17'sd0, 1'b1};
    localparam t_turn_result UNTYPED      = '{25'd0, 17'sd0, 1'b0};

    localparam int N_DIRECTED = 23;
    localparam t_vector DIRECTED [N_DIRECTED] = '{
        // zero-length segments: no turn on the first, zero turn after
        '{'{C0,   C0,   C0,   C0},   1'b1, NO_TURN_ZERO},
        '{'{CMIN, CMIN, CMIN, CMIN}, 1'b1, TURN_ZERO},
        '{'{CMAX, CMAX, CMAX, CMAX}, 1'b1, TURN_ZERO},
        // unit steps along each axis and one diagonal
        '{'{C0,   C0,   CP1,  C0},   1'b0, UNTYPED},
        '{'{C0,   C0,   C0,   CP1},  1'b0, UNTYPED},
        '{'{C0,   C0,   CM1,  C0},   1'b0, UNTYPED},
        '{'{C0,   C0,   C0,   CM1},  1'b0, UNTYPED},
        '{'{C0,   C0,   CP1,  CM1},  1'b0, UNTYPED},
        // longest segments
        '{'{CMIN, CMIN, CMAX, CMAX}, 1'b0, UNTYPED},
        '{'{CMAX, CMAX, CMIN, CMIN}, 1'b0, UNTYPED},
        '{'{CMIN, C0,   CMAX, C0},   1'b0, UNTYPED},
        '{'{CMAX, C0,   CMIN, C0},   1'b0, UNTYPED},
        '{'{C0,   CMIN, C0,   CMAX}, 1'b0, UNTYPED},
        '{'{C0,   CMAX, C0,   CMIN}, 1'b0, UNTYPED},
        '{'{CMIN, CMAX, CMAX, CMIN}, 1'b0, UNTYPED},
        '{'{CMAX, CMIN, CMIN, CMAX}, 1'b0, UNTYPED},
        // headings next to 0/360 and 180, turns across the wrap
        '{'{CMIN, C0,   CMAX, CM1},  1'b0, UNTYPED},
        '{'{CMIN, CM1,  CMAX, C0},   1'b0, UNTYPED},
        '{'{CMIN, C0,   CMAX, CM1},  1'b0, UNTYPED},
        '{'{CMAX, C0,   CMIN, CP1},  1'b0, UNTYPED},
        '{'{CMAX, C0,   CMIN, CM1},  1'b0, UNTYPED},
        '{'{C0,   C0,   C0,   C0},   1'b0, UNTYPED},
        '{'{CMAX, C0,   CMIN, C0},   1'b0, UNTYPED}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    slht_seg_if #(.COORD_WIDTH(COORD_W)) seg_ch ();
    slht_res_if #(.COORD_WIDTH(COORD_W), .FRAC_BITS(FRAC_W)) res_ch ();

    segment_length_heading_turn #(
        .COORD_WIDTH(COORD_W),
        .FRAC_BITS  (FRAC_W)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_seg  (seg_ch),
        .o_res  (res_ch)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    logic [ANG_W-1:0] heading_prev;
    logic             heading_seen;
    t_turn_result     results_due [$];
    int               mismatch_count = 0;
    int               send_gap_pct   = 34;
    int               recv_stall_pct = 57;

    function automatic t_turn_result predict_segment(input t_segment s);
        longint       dx, dy, x, y, z, xs, ys, diff, head, len;
        int           i;
        t_turn_result r;
        dx   = longint'(s.ex) - longint'(s.sx);
        dy   = longint'(s.ey) - longint'(s.sy);
        head = 0;
        len  = 0;
        if (dx != 0 || dy != 0) begin
            x = (dx * GAIN_Q30) >>> GAIN_SHIFT;
            y = (dy * GAIN_Q30) >>> GAIN_SHIFT;
            z = 0;
            if (dx < 0) begin
                x = -x;
                y = -y;
                z = Z_HALF_TURN;
            end
            for (i = 0; i < N_STEPS; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ATAN_DEG[i];
                end else begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ATAN_DEG[i];
                end
            end
            if (z < 0) z = z + Z_FULL_TURN;
            head = (z + (64'sd1 <<< (Z_FRAC - FRAC_W - 1))) >>> (Z_FRAC - FRAC_W);
            if (head >= FULL_TURN) head = head - FULL_TURN;
            if (x > 0) len = (x + (64'sd1 <<< (LEN_GUARD - 1))) >>> LEN_GUARD;
            if (len > LEN_MAX) len = LEN_MAX;
        end
        r.length = len[LEN_W-1:0];
        if (heading_seen) begin
            diff = longint'(heading_prev) - head;
            if (diff > HALF_TURN) diff = diff - FULL_TURN;
            else if (diff < -HALF_TURN) diff = diff + FULL_TURN;
            r.turn       = diff[ANG_W-1:0];
            r.turn_valid = 1'b1;
        end else begin
            r.turn       = '0;
            r.turn_valid = 1'b0;
        end
        heading_prev = head[ANG_W-1:0];
        heading_seen = 1'b1;
        return r;
    endfunction

    function automatic t_segment random_segment();
        t_segment                  s;
        int                        kind;
        logic signed [COORD_W-1:0] corners [5];
        corners = '{CMIN, CMAX, C0, CM1, CP1};
        kind = $urandom_range(99);
        s.sx = COORD_W'($urandom);
        s.sy = COORD_W'($urandom);
        s.ex = COORD_W'($urandom);
        s.ey = COORD_W'($urandom);
        if (kind < 10) begin
            s.ex = s.sx;
            s.ey = s.sy;
        end else if (kind < 35) begin
            s.ex = s.sx + COORD_W'($urandom_range(128)) - 16'd64;
            s.ey = s.sy + COORD_W'($urandom_range(128)) - 16'd64;
        end else if (kind < 45) begin
            // nearly axis aligned, headings around the quadrant boundaries
            if ($urandom_range(1) == 1) s.ey = s.sy + COORD_W'($urandom_range(4)) - 16'd2;
            else s.ex = s.sx + COORD_W'($urandom_range(4)) - 16'd2;
        end else if (kind < 55) begin
            s.sx = corners[$urandom_range(4)];
            s.sy = corners[$urandom_range(4)];
            s.ex = corners[$urandom_range(4)];
            s.ey = corners[$urandom_range(4)];
        end
        return s;
    endfunction

    task automatic send_segment(input t_segment s, input logic typed, input t_turn_result want);
        t_turn_result calc;
        while ($urandom_range(99) < send_gap_pct) begin
            seg_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        seg_ch.valid   <= 1'b1;
        seg_ch.start_x <= s.sx;
        seg_ch.start_y <= s.sy;
        seg_ch.end_x   <= s.ex;
        seg_ch.end_y   <= s.ey;
        @(posedge i_clk);
        while (!seg_ch.ready) @(posedge i_clk);
        calc = predict_segment(s);
        results_due.push_back(typed ? want : calc);
    endtask

    initial begin
        t_turn_result want;
        t_turn_result got;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_ch.valid && res_ch.ready) begin
                got = '{res_ch.seg_length, res_ch.turn_angle, res_ch.turn_valid};
                if (results_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected item: len %0d turn %0d tv %0b",
                                 got.length, got.turn, got.turn_valid);
                end else begin
                    want = results_due.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("mismatch: want len %0d turn %0d tv %0b, got len %0d turn %0d tv %0b",
                                     want.length, want.turn, want.turn_valid,
                                     got.length, got.turn, got.turn_valid);
                    end
                end
            end
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        int n;
        i_rst_n        <= 1'b0;
        seg_ch.valid   <= 1'b0;
        seg_ch.start_x <= '0;
        seg_ch.start_y <= '0;
        seg_ch.end_x   <= '0;
        seg_ch.end_y   <= '0;
        heading_prev = '0;
        heading_seen = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (n = 0; n < N_DIRECTED; n++)
            send_segment(DIRECTED[n].seg, DIRECTED[n].typed, DIRECTED[n].want);
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                send_gap_pct   = 57;
                recv_stall_pct = 34;
            end
            if (n == 2 * RANDOM_ITEMS / 3) begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            send_segment(random_segment(), 1'b0, UNTYPED);
        end
        seg_ch.valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && results_due.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("tb_top: errors");
        $finish;
    end

endmodule

/* sim.f */
hdl/slht_pkg.sv
hdl/slht_seg_if.sv
hdl/slht_res_if.sv
hdl/slht_front.sv
hdl/slht_fifo.sv
hdl/slht_back.sv
hdl/segment_length_heading_turn.sv
dv/tb_top.sv
